// ===== rtl/gaps_pkg.sv =====
package gaps_pkg;

   localparam int MAX_WIDTH_DEF  = 8;
   localparam int MAX_HEIGHT_DEF = 8;
   localparam int OPEN_DEPTH_DEF = 256;

   localparam int STEP_STRAIGHT = 10;
   localparam int STEP_DIAGONAL = 14;
   localparam int RESULT_LIMIT  = 64;

   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_WALL = 2'd1;
   localparam logic [1:0] KIND_DOOR = 2'd2;

   localparam logic [1:0] RSP_FOUND    = 2'd0;
   localparam logic [1:0] RSP_NO_PATH  = 2'd1;
   localparam logic [1:0] RSP_REJECT   = 2'd2;
   localparam logic [1:0] RSP_OVERFLOW = 2'd3;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam logic [3:0] DIM_RESET = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_KSRC, ST_KDST, ST_CHECK, ST_POP, ST_SC_RD, ST_SC_CMP, ST_SH_RD,
      ST_SH_WR, ST_G_USE, ST_NB_RD, ST_NB_EVAL, ST_EMIT, ST_PAR_USE, ST_FAIL
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_RD_SRC, OP_RD_DST, OP_INIT, OP_SCAN_START, OP_SCAN_RD,
      OP_SCAN_CMP, OP_SHIFT_RD, OP_SHIFT_WR, OP_POP_DONE, OP_G_USE, OP_NB_NEXT,
      OP_NB_RD, OP_NB_EVAL, OP_LOAD_PATH, OP_PAR_USE, OP_LOAD_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic reject;
      logic open_empty;
      logic scan_last;
      logic shift_done;
      logic cur_is_dst;
      logic nb_in_range;
      logic k_last;
      logic overflow;
      logic path_final;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [1:0] step_dx(input logic [2:0] k);
      case (k)
         3'd0, 3'd4, 3'd5: return -2'sd1;
         3'd1, 3'd3:       return 2'sd0;
         default:          return 2'sd1;
      endcase
   endfunction

   function automatic logic signed [1:0] step_dy(input logic [2:0] k);
      case (k)
         3'd0, 3'd2:       return 2'sd0;
         3'd1, 3'd4, 3'd6: return -2'sd1;
         default:          return 2'sd1;
      endcase
   endfunction

   // register value 0 acts as 1, values above the maximum clamp to it
   function automatic logic [7:0] dim_in_use(input logic [3:0] r, input logic [7:0] mx);
      if (r == 4'd0) return 8'd1;
      if ({4'd0, r} > mx) return mx;
      return {4'd0, r};
   endfunction

endpackage

// ===== rtl/gaps_ram.sv =====
module gaps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gaps_ctrl.sv =====
module gaps_ctrl import gaps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   input  dp_status_type stat,
   output dp_cmd_type    cmd,
   output logic          req_stall
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     fail_ff, fail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fail_ff  <= RSP_FOUND;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fail_in   = fail_ff;
      cmd.op    = OP_NONE;
      cmd.code  = fail_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (req_cmd) state_in = ST_KSRC;
            end
         end
         ST_KSRC: begin
            cmd.op   = OP_RD_SRC;
            state_in = ST_KDST;
         end
         ST_KDST: begin
            cmd.op   = OP_RD_DST;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.reject) begin
               fail_in  = RSP_REJECT;
               state_in = ST_FAIL;
            end else begin
               cmd.op   = OP_INIT;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (stat.open_empty) begin
               fail_in  = RSP_NO_PATH;
               state_in = ST_FAIL;
            end else begin
               cmd.op   = OP_SCAN_START;
               state_in = ST_SC_RD;
            end
         end
         ST_SC_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            cmd.op   = OP_SCAN_CMP;
            state_in = stat.scan_last ? ST_SH_RD : ST_SC_RD;
         end
         ST_SH_RD: begin
            if (stat.shift_done) begin
               cmd.op   = OP_POP_DONE;
               state_in = stat.cur_is_dst ? ST_EMIT : ST_G_USE;
            end else begin
               cmd.op   = OP_SHIFT_RD;
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            cmd.op   = OP_SHIFT_WR;
            state_in = ST_SH_RD;
         end
         ST_G_USE: begin
            cmd.op   = OP_G_USE;
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            if (stat.nb_in_range) begin
               cmd.op   = OP_NB_RD;
               state_in = ST_NB_EVAL;
            end else begin
               cmd.op   = OP_NB_NEXT;
               state_in = stat.k_last ? ST_POP : ST_NB_RD;
            end
         end
         ST_NB_EVAL: begin
            if (stat.overflow) begin
               fail_in  = RSP_OVERFLOW;
               state_in = ST_FAIL;
            end else begin
               cmd.op   = OP_NB_EVAL;
               state_in = stat.k_last ? ST_POP : ST_NB_RD;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = OP_LOAD_PATH;
               state_in = stat.path_final ? ST_IDLE : ST_PAR_USE;
            end
         end
         ST_PAR_USE: begin
            cmd.op   = OP_PAR_USE;
            state_in = ST_EMIT;
         end
         ST_FAIL: begin
            if (stat.out_free) begin
               cmd.op   = OP_LOAD_FAIL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/gaps_dp.sv =====
module gaps_dp import gaps_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int OPEN_DEPTH = OPEN_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type stat,
   input  logic          req_cmd,
   input  logic [2:0]    req_cell_x,
   input  logic [2:0]    req_cell_y,
   input  logic [1:0]    req_cell_kind,
   input  logic [2:0]    req_src_x,
   input  logic [2:0]    req_src_y,
   input  logic [2:0]    req_dst_x,
   input  logic [2:0]    req_dst_y,
   input  logic          csr_valid,
   input  logic          csr_index,
   input  logic [3:0]    csr_data,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [2:0]    rsp_path_x,
   output logic [2:0]    rsp_path_y,
   output logic [1:0]    rsp_status,
   output logic          rsp_last
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int CW     = XW + YW;
   localparam int CELLS  = 1 << CW;
   localparam int COST_W = $clog2(CELLS * STEP_DIAGONAL
                                  + (MAX_WIDTH + MAX_HEIGHT) * STEP_STRAIGHT + 1);
   localparam int OW     = $clog2(OPEN_DEPTH);
   localparam int OCW    = $clog2(OPEN_DEPTH + 1);
   localparam int EW     = CW + COST_W;
   localparam int LW     = $clog2(RESULT_LIMIT);

   function automatic logic [CW-1:0] cell_of(input logic [2:0] x, input logic [2:0] y);
      logic [7:0] xe;
      logic [7:0] ye;
      xe = {5'd0, x};
      ye = {5'd0, y};
      return {ye[YW-1:0], xe[XW-1:0]};
   endfunction

   function automatic logic [COST_W-1:0] heur(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [XW-1:0]     ax;
      logic [YW-1:0]     ay;
      logic [COST_W-1:0] s;
      ax = (a[XW-1:0] > b[XW-1:0]) ? a[XW-1:0] - b[XW-1:0] : b[XW-1:0] - a[XW-1:0];
      ay = (a[CW-1:XW] > b[CW-1:XW]) ? a[CW-1:XW] - b[CW-1:XW] : b[CW-1:XW] - a[CW-1:XW];
      s  = COST_W'(ax) + COST_W'(ay);
      return (s << 3) + (s << 1);
   endfunction

   logic [3:0]        grid_w_ff, grid_h_ff;
   logic [2:0]        src_x_ff, src_y_ff, dst_x_ff, dst_y_ff;
   logic [1:0]        src_kind_ff;
   logic [OCW-1:0]    count_ff, scan_idx_ff, sh_idx_ff;
   logic [COST_W-1:0] best_f_ff, g_ff;
   logic [CW-1:0]     best_cell_ff, nb_cell_ff, path_cell_ff;
   logic [2:0]        k_ff;
   logic [LW-1:0]     emit_n_ff;
   logic [CELLS-1:0]  kind_vld_ff, cost_vld_ff;
   logic              kvld_q_ff, cvld_q_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [2:0]        rsp_x_ff, rsp_y_ff;
   logic [1:0]        rsp_status_ff;

   logic [7:0]        w_use, h_use;
   logic [CW-1:0]     src_cell, dst_cell, wr_cell, nb_cell;
   logic              in_store, in_rng;
   logic [XW:0]       nx_e;
   logic [YW:0]       ny_e;
   logic [1:0]        kind_eff;
   logic [COST_W-1:0] ng, nb_f, ent_f, cost_q;
   logic              closed_q;
   logic [CW-1:0]     ent_cell;
   logic              upd, push, take, out_free;
   logic [OCW-1:0]    sh_next;
   logic [7:0]        px8, py8;

   logic              kind_wr_en, cost_wr_en, par_wr_en, open_wr_en;
   logic [1:0]        kind_wr_data, kind_rd;
   logic [CW-1:0]     kind_rd_addr, cost_wr_addr, cost_rd_addr, par_rd;
   logic [COST_W:0]   cost_wr_data, cost_rd;
   logic [OW-1:0]     open_wr_addr, open_rd_addr;
   logic [EW-1:0]     open_wr_data, open_rd;

   assign w_use    = dim_in_use(grid_w_ff, 8'(MAX_WIDTH));
   assign h_use    = dim_in_use(grid_h_ff, 8'(MAX_HEIGHT));
   assign src_cell = cell_of(src_x_ff, src_y_ff);
   assign dst_cell = cell_of(dst_x_ff, dst_y_ff);
   assign wr_cell  = cell_of(req_cell_x, req_cell_y);
   assign in_store = ({5'd0, req_cell_x} < 8'(MAX_WIDTH)) && ({5'd0, req_cell_y} < 8'(MAX_HEIGHT));
   assign in_rng   = ({5'd0, src_x_ff} < w_use) && ({5'd0, src_y_ff} < h_use)
                  && ({5'd0, dst_x_ff} < w_use) && ({5'd0, dst_y_ff} < h_use);

   // a carry into the top bit is either a step below zero or past the store edge
   assign nx_e    = {1'b0, best_cell_ff[XW-1:0]} + (XW+1)'(step_dx(k_ff));
   assign ny_e    = {1'b0, best_cell_ff[CW-1:XW]} + (YW+1)'(step_dy(k_ff));
   assign nb_cell = {ny_e[YW-1:0], nx_e[XW-1:0]};

   // closed flag rides in the top bit of the cost word
   assign cost_q   = cost_rd[COST_W-1:0];
   assign closed_q = cvld_q_ff && cost_rd[COST_W];

   assign kind_eff = kvld_q_ff ? kind_rd : KIND_OPEN;
   assign ng       = g_ff + ((k_ff < 3'd4) ? COST_W'(STEP_STRAIGHT) : COST_W'(STEP_DIAGONAL));
   assign nb_f     = ng + heur(nb_cell_ff, dst_cell);
   assign upd      = (kind_eff == KIND_OPEN) && (!cvld_q_ff || (cost_q > ng));
   assign push     = upd && !closed_q;
   assign ent_f    = open_rd[COST_W-1:0];
   assign ent_cell = open_rd[EW-1:COST_W];
   assign take     = (scan_idx_ff == '0) || (ent_f < best_f_ff);
   assign sh_next  = sh_idx_ff + OCW'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign px8      = 8'(path_cell_ff[XW-1:0]);
   assign py8      = 8'(path_cell_ff[CW-1:XW]);

   always_comb begin
      stat.reject      = !in_rng || (src_kind_ff == KIND_WALL) || (kind_eff == KIND_WALL)
                      || ((src_x_ff == dst_x_ff) && (src_y_ff == dst_y_ff));
      stat.open_empty  = (count_ff == '0);
      stat.scan_last   = ((scan_idx_ff + OCW'(1)) == count_ff);
      stat.shift_done  = (sh_next == count_ff);
      stat.cur_is_dst  = (best_cell_ff == dst_cell);
      stat.nb_in_range = !nx_e[XW] && !ny_e[YW]
                      && (8'(nx_e[XW-1:0]) < w_use) && (8'(ny_e[YW-1:0]) < h_use);
      stat.k_last      = (k_ff == 3'd7);
      stat.overflow    = push && (count_ff == OCW'(OPEN_DEPTH));
      stat.path_final  = (path_cell_ff == src_cell) || (emit_n_ff == LW'(RESULT_LIMIT - 1));
      stat.out_free    = out_free;
   end

   always_comb begin
      kind_wr_en   = (cmd.op == OP_ACCEPT) && !req_cmd && in_store;
      kind_wr_data = (req_cell_kind > KIND_DOOR) ? KIND_WALL : req_cell_kind;
      case (cmd.op)
         OP_RD_SRC: kind_rd_addr = src_cell;
         OP_RD_DST: kind_rd_addr = dst_cell;
         default:   kind_rd_addr = nb_cell;
      endcase
      cost_rd_addr = (cmd.op == OP_POP_DONE) ? best_cell_ff : nb_cell;
      cost_wr_en   = (cmd.op == OP_INIT) || (cmd.op == OP_G_USE)
                  || ((cmd.op == OP_NB_EVAL) && upd);
      case (cmd.op)
         OP_INIT: begin
            cost_wr_addr = src_cell;
            cost_wr_data = '0;
         end
         // the served cell is marked closed, its cost kept
         OP_G_USE: begin
            cost_wr_addr = best_cell_ff;
            cost_wr_data = {1'b1, cost_q};
         end
         default: begin
            cost_wr_addr = nb_cell_ff;
            cost_wr_data = {closed_q, ng};
         end
      endcase
      par_wr_en    = (cmd.op == OP_NB_EVAL) && upd;
      open_rd_addr = (cmd.op == OP_SCAN_RD) ? scan_idx_ff[OW-1:0] : sh_next[OW-1:0];
      case (cmd.op)
         OP_INIT: begin
            open_wr_en   = 1'b1;
            open_wr_addr = '0;
            open_wr_data = {src_cell, heur(src_cell, dst_cell)};
         end
         OP_SHIFT_WR: begin
            open_wr_en   = 1'b1;
            open_wr_addr = sh_idx_ff[OW-1:0];
            open_wr_data = open_rd;
         end
         OP_NB_EVAL: begin
            open_wr_en   = push;
            open_wr_addr = count_ff[OW-1:0];
            open_wr_data = {nb_cell_ff, nb_f};
         end
         default: begin
            open_wr_en   = 1'b0;
            open_wr_addr = count_ff[OW-1:0];
            open_wr_data = {nb_cell_ff, nb_f};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kvld_q_ff <= kind_vld_ff[kind_rd_addr];
      cvld_q_ff <= cost_vld_ff[cost_rd_addr];
      if (reset) begin
         grid_w_ff    <= DIM_RESET;
         grid_h_ff    <= DIM_RESET;
         count_ff     <= '0;
         kind_vld_ff  <= '0;
         cost_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_GRID_WIDTH:  grid_w_ff <= csr_data;
               CSR_GRID_HEIGHT: grid_h_ff <= csr_data;
               default:         grid_w_ff <= grid_w_ff;
            endcase
         end
         if (kind_wr_en) kind_vld_ff[wr_cell] <= 1'b1;
         if (out_free && (cmd.op != OP_LOAD_PATH) && (cmd.op != OP_LOAD_FAIL)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_ACCEPT: begin
               src_x_ff <= req_src_x;
               src_y_ff <= req_src_y;
               dst_x_ff <= req_dst_x;
               dst_y_ff <= req_dst_y;
            end
            OP_RD_DST: src_kind_ff <= kind_eff;
            OP_INIT: begin
               cost_vld_ff  <= CELLS'(1) << src_cell;
               count_ff     <= OCW'(1);
               path_cell_ff <= dst_cell;
               emit_n_ff    <= '0;
            end
            OP_SCAN_START: scan_idx_ff <= '0;
            OP_SCAN_CMP: begin
               // sh_idx holds the best index so far, then becomes the shift pointer
               if (take) begin
                  best_f_ff    <= ent_f;
                  best_cell_ff <= ent_cell;
                  sh_idx_ff    <= scan_idx_ff;
               end
               scan_idx_ff <= scan_idx_ff + OCW'(1);
            end
            OP_SHIFT_WR: sh_idx_ff <= sh_next;
            OP_POP_DONE: count_ff <= count_ff - OCW'(1);
            OP_G_USE: begin
               g_ff <= cost_q;
               k_ff <= '0;
            end
            OP_NB_NEXT: k_ff <= k_ff + 3'd1;
            OP_NB_RD:   nb_cell_ff <= nb_cell;
            OP_NB_EVAL: begin
               if (upd) cost_vld_ff[nb_cell_ff] <= 1'b1;
               if (push) count_ff <= count_ff + OCW'(1);
               k_ff <= k_ff + 3'd1;
            end
            OP_LOAD_PATH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_x_ff      <= px8[2:0];
               rsp_y_ff      <= py8[2:0];
               rsp_status_ff <= RSP_FOUND;
               rsp_last_ff   <= stat.path_final;
               emit_n_ff     <= emit_n_ff + LW'(1);
            end
            OP_PAR_USE: path_cell_ff <= par_rd;
            OP_LOAD_FAIL: begin
               rsp_valid_ff  <= 1'b1;
               rsp_x_ff      <= 3'd0;
               rsp_y_ff      <= 3'd0;
               rsp_status_ff <= cmd.code;
               rsp_last_ff   <= 1'b1;
            end
            default: k_ff <= k_ff;
         endcase
      end
   end

   gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_kind_ram (
      .clock(clock), .wr_en(kind_wr_en), .wr_addr(wr_cell), .wr_data(kind_wr_data),
      .rd_addr(kind_rd_addr), .rd_data(kind_rd)
   );

   gaps_ram #(.WIDTH(COST_W + 1), .DEPTH(CELLS)) u_cost_ram (
      .clock(clock), .wr_en(cost_wr_en), .wr_addr(cost_wr_addr), .wr_data(cost_wr_data),
      .rd_addr(cost_rd_addr), .rd_data(cost_rd)
   );

   gaps_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_parent_ram (
      .clock(clock), .wr_en(par_wr_en), .wr_addr(nb_cell_ff), .wr_data(best_cell_ff),
      .rd_addr(path_cell_ff), .rd_data(par_rd)
   );

   gaps_ram #(.WIDTH(EW), .DEPTH(OPEN_DEPTH)) u_open_ram (
      .clock(clock), .wr_en(open_wr_en), .wr_addr(open_wr_addr), .wr_data(open_wr_data),
      .rd_addr(open_rd_addr), .rd_data(open_rd)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_path_x = rsp_x_ff;
   assign rsp_path_y = rsp_y_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== rtl/grid_astar_path_search.sv =====
// Flow: a cell write request is taken in the idle state; a search runs endpoint checks, then
//   per served cell a scan and shift of the open list and a neighbour pass, then sends
//   the path cells one by one.
// Requests: one at a time; the scan and shift of the registered-read open-list RAM
//   set the search time.
// Reset: synchronous, active high; grid reads all open, size returns to 8x8, no result held.
module grid_astar_path_search import gaps_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int OPEN_DEPTH = OPEN_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [2:0] req_cell_x,
   input  logic [2:0] req_cell_y,
   input  logic [1:0] req_cell_kind,
   input  logic [2:0] req_src_x,
   input  logic [2:0] req_src_y,
   input  logic [2:0] req_dst_x,
   input  logic [2:0] req_dst_y,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_path_x,
   output logic [2:0] rsp_path_y,
   output logic [1:0] rsp_status,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [3:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   assign csr_ready = 1'b1;

   gaps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_cmd(req_cmd),
      .stat(stat), .cmd(cmd), .req_stall(req_stall)
   );

   gaps_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .OPEN_DEPTH(OPEN_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_cmd(req_cmd), .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_cell_kind(req_cell_kind), .req_src_x(req_src_x), .req_src_y(req_src_y),
      .req_dst_x(req_dst_x), .req_dst_y(req_dst_y),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .rsp_path_x(rsp_path_x),
      .rsp_path_y(rsp_path_y), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

endmodule

// ===== rtl/gaps_checker.sv =====
module gaps_checker import gaps_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_cmd,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_path_x,
   input logic [2:0] rsp_path_y,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_path_x) && $stable(rsp_path_y)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   a_mid_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == RSP_FOUND)
      else $error("non-final result without found status");

   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != RSP_FOUND |-> rsp_last && rsp_path_x == 3'd0
         && rsp_path_y == 3'd0)
      else $error("failure result malformed");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd |=> req_stall)
      else $error("search request did not hold off the next request");

endmodule

bind grid_astar_path_search gaps_checker u_gaps_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top import gaps_pkg::*; ();

   localparam int GRID_W = MAX_WIDTH_DEF;
   localparam int GRID_CELLS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
   localparam int NO_LINK = -1;
   localparam logic [1:0] KIND_UNUSED = 2'd3;   // stored as a wall

   typedef struct packed {
      logic       cmd;
      logic [2:0] cx;
      logic [2:0] cy;
      logic [1:0] kind;
      logic [2:0] sx;
      logic [2:0] sy;
      logic [2:0] dx;
      logic [2:0] dy;
   } grid_req_type;

   typedef struct packed {
      logic [2:0] x;
      logic [2:0] y;
      logic [1:0] status;
      logic       last;
   } hop_type;

   logic       clock, reset;
   logic       req_valid, req_stall, req_cmd;
   logic [2:0] req_cell_x, req_cell_y, req_src_x, req_src_y, req_dst_x, req_dst_y;
   logic [1:0] req_cell_kind;
   logic       rsp_valid, rsp_stall, rsp_last;
   logic [2:0] rsp_path_x, rsp_path_y;
   logic [1:0] rsp_status;
   logic       csr_valid, csr_ready, csr_index;
   logic [3:0] csr_data;

   grid_astar_path_search uut (.*);

   grid_req_type pending_reqs[$];
   hop_type      route_q[$];
   grid_req_type cur_req;
   logic [1:0] grid_kind[GRID_CELLS];
   int        g_cost[GRID_CELLS];
   int        link[GRID_CELLS];
   bit        closed[GRID_CELLS];
   logic [3:0] width_reg, height_reg;
   int        errors;
   int        hold_cycles;
   bit        calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int dim_eff(logic [3:0] r, int mx);
      if (r == 4'd0) return 1;
      return (r > mx) ? mx : int'(r);
   endfunction

   function automatic int manhattan(int x, int y, int gx, int gy);
      return ((x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y)) * STEP_STRAIGHT;
   endfunction

   function automatic logic [1:0] run_astar(int sx, int sy, int dx, int dy);
      int ddx[8] = '{-1, 0, 1, 0, -1, -1, 1, 1};
      int ddy[8] = '{0, -1, 0, 1, -1, 1, -1, 1};
      int ol_cell[$];
      int ol_f[$];
      int w, h, src, dst, cur, best, cx, cy, nx, ny, n, ng;
      w = dim_eff(width_reg, MAX_WIDTH_DEF);
      h = dim_eff(height_reg, MAX_HEIGHT_DEF);
      if (sx >= w || sy >= h || dx >= w || dy >= h) return RSP_REJECT;
      src = sy * GRID_W + sx;
      dst = dy * GRID_W + dx;
      if (grid_kind[src] == KIND_WALL || grid_kind[dst] == KIND_WALL || src == dst)
         return RSP_REJECT;
      for (int i = 0; i < GRID_CELLS; i++) begin
         g_cost[i] = 32'h7fff_ffff;
         link[i] = NO_LINK;
         closed[i] = 1'b0;
      end
      g_cost[src] = 0;
      ol_cell.insert(ol_cell.size(), src);
      ol_f.insert(ol_f.size(), manhattan(sx, sy, dx, dy));
      forever begin
         if (ol_cell.size() == 0) return RSP_NO_PATH;
         best = 0;
         // strict compare keeps the earliest entry on a tie
         for (int i = 1; i < ol_cell.size(); i++)
            if (ol_f[i] < ol_f[best]) best = i;
         cur = ol_cell[best];
         ol_cell.delete(best);
         ol_f.delete(best);
         closed[cur] = 1'b1;
         if (cur == dst) return RSP_FOUND;
         cx = cur % GRID_W;
         cy = cur / GRID_W;
         for (int k = 0; k < 8; k++) begin
            nx = cx + ddx[k];
            ny = cy + ddy[k];
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
            n = ny * GRID_W + nx;
            if (grid_kind[n] != KIND_OPEN) continue;
            ng = g_cost[cur] + ((k < 4) ? STEP_STRAIGHT : STEP_DIAGONAL);
            if (g_cost[n] > ng) begin
               g_cost[n] = ng;
               link[n] = cur;
               if (!closed[n]) begin
                  if (ol_cell.size() >= OPEN_DEPTH_DEF) return RSP_OVERFLOW;
                  ol_cell.insert(ol_cell.size(), n);
                  ol_f.insert(ol_f.size(), ng + manhattan(nx, ny, dx, dy));
               end
            end
         end
      end
   endfunction

   function automatic void apply_request(grid_req_type r);
      logic [1:0] st;
      int spot, cnt;
      hop_type hop;
      if (!r.cmd) begin
         grid_kind[{r.cy, r.cx}] = (r.kind == KIND_UNUSED) ? KIND_WALL : r.kind;
         return;
      end
      st = run_astar(r.sx, r.sy, r.dx, r.dy);
      if (st != RSP_FOUND) begin
         hop = '{x: 3'd0, y: 3'd0, status: st, last: 1'b1};
         route_q.insert(route_q.size(), hop);
         return;
      end
      spot = {r.dy, r.dx};
      cnt = 0;
      forever begin
         hop.x = 3'(spot % GRID_W);
         hop.y = 3'(spot / GRID_W);
         hop.status = RSP_FOUND;
         hop.last = (link[spot] == NO_LINK || cnt == RESULT_LIMIT - 1);
         route_q.insert(route_q.size(), hop);
         cnt++;
         if (hop.last) break;
         spot = link[spot];
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_request(cur_req);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
               cur_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= cur_req.cmd;
               req_cell_x <= cur_req.cx;
               req_cell_y <= cur_req.cy;
               req_cell_kind <= cur_req.kind;
               req_src_x <= cur_req.sx;
               req_src_y <= cur_req.sy;
               req_dst_x <= cur_req.dx;
               req_dst_y <= cur_req.dy;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      hop_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (route_q.size() == 0) begin
               $error("unexpected result x=%0d y=%0d status=%0d last=%0d",
                      rsp_path_x, rsp_path_y, rsp_status, rsp_last);
               errors++;
            end else begin
               want = route_q.pop_front();
               if (rsp_path_x !== want.x) begin
                  $error("path_x expected %0d actual %0d", want.x, rsp_path_x);
                  errors++;
               end
               if (rsp_path_y !== want.y) begin
                  $error("path_y expected %0d actual %0d", want.y, rsp_path_y);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_last);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 38);
         end
      end
   end

   function automatic grid_req_type mk(logic cmd, int cx, int cy, logic [1:0] kind,
                                       int sx, int sy, int dx, int dy);
      grid_req_type r;
      r = '{cmd, cx[2:0], cy[2:0], kind, sx[2:0], sy[2:0], dx[2:0], dy[2:0]};
      return r;
   endfunction

   function automatic grid_req_type rand_req(logic cmd);
      grid_req_type r;
      r = grid_req_type'(22'($urandom));
      r.cmd = cmd;
      if (!cmd && $urandom_range(9) < 6) r.kind = KIND_OPEN;
      return r;
   endfunction

   function automatic void queue_req(grid_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || route_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [3:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_WIDTH) width_reg = val;
      else height_reg = val;
   endtask

   initial begin
      logic [3:0] dims[5][2] = '{'{4'd15, 4'd15}, '{4'd3, 4'd5}, '{4'd8, 4'd2},
                                 '{4'd0, 4'd1}, '{4'd8, 4'd8}};
      errors = 0;
      hold_cycles = 0;
      calm = 1'b0;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      foreach (grid_kind[i]) grid_kind[i] = KIND_OPEN;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      {req_cell_x, req_cell_y, req_cell_kind} = '0;
      {req_src_x, req_src_y, req_dst_x, req_dst_y} = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = 4'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: kinds, rejections, door endpoints, boxed-in source
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 0, 0, 7, 7));
      queue_req(mk(1'b0, 3, 3, KIND_WALL, 0, 0, 0, 0));
      queue_req(mk(1'b0, 4, 4, KIND_DOOR, 0, 0, 0, 0));
      queue_req(mk(1'b0, 0, 7, KIND_UNUSED, 0, 0, 0, 0));
      queue_req(mk(1'b0, 7, 0, KIND_DOOR, 0, 0, 0, 0));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 0, 0, 7, 7));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 3, 3, 0, 0));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 0, 0, 3, 3));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 0, 7, 2, 2));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 5, 5, 5, 5));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 0, 0, 4, 4));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 4, 4, 6, 6));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 7, 0, 0, 6));
      queue_req(mk(1'b0, 1, 0, KIND_WALL, 0, 0, 0, 0));
      queue_req(mk(1'b0, 0, 1, KIND_WALL, 0, 0, 0, 0));
      queue_req(mk(1'b0, 1, 1, KIND_DOOR, 0, 0, 0, 0));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 0, 0, 5, 5));
      queue_req(mk(1'b0, 1, 1, KIND_OPEN, 0, 0, 0, 0));
      queue_req(mk(1'b1, 0, 0, KIND_OPEN, 7, 7, 0, 0));
      drain();

      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_GRID_WIDTH, dims[p][0]);
         write_csr(CSR_GRID_HEIGHT, dims[p][1]);
         calm = (p == 1);
         for (int i = 0; i < 25; i++)
            queue_req(rand_req(1'($urandom_range(1))));
         // long receiver hold while requests keep coming
         if (p == 2) hold_cycles = 400;
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("[grid_astar_path_search] OK");
      end else begin
         $display("[grid_astar_path_search] ERROR");
      end
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("[grid_astar_path_search] ERROR");
      $finish;
   end

endmodule
